[sv/bas_pkg.sv]
`timescale 1ns / 1ps

package bas_pkg;

   localparam int VAL_W = 32;   // stored element width
   localparam int POS_W = 10;   // reported position width
   localparam int CNT_W = 11;   // reported element count width

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

[sv/bitonic_array_search.sv]
`timescale 1ns / 1ps
// Push, pop, no-op and empty query: response valid the cycle after the request.
// Query: probes are a store read state, then a compare state; a search that
//   runs out ends in its read state; a done state posts when the slot frees.
//   At 1024 elements 10 peak and up to 20 value probes. One request in flight at a time.
// Reset clears the element count, the state machine and rsp_tvalid; the store
//   keeps its contents and needs no clearing pass.

module bitonic_array_search #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_value (signed)
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] position, [20:10] element_count, [23:21] zero
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] found
);

   import bas_pkg::*;

   localparam int IW = $clog2(MAX_ELEMENTS);       // store address width
   localparam int CW = $clog2(MAX_ELEMENTS + 1);   // count width, holds MAX_ELEMENTS

   // Each search phase alternates a read state (address issued to the
   // store) and a compare state (registered read data is checked).
   typedef enum logic [2:0] {
      S_IDLE,
      S_PK_RD,
      S_PK_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } state_type;

   // Element store: one write port, two read ports with registered data.
   logic signed [VAL_W-1:0] mem [MAX_ELEMENTS];
   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   logic [IW-1:0]           rd_addr_a;
   logic [IW-1:0]           rd_addr_b;
   logic signed [VAL_W-1:0] rd_a_ff;
   logic signed [VAL_W-1:0] rd_b_ff;

   // Control and datapath registers.
   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hi_ff, hi_in;      // inclusive in peak phase, exclusive end later
   logic [CW-1:0]           mid_ff, mid_in;
   logic [CW-1:0]           peak_ff, peak_in;
   logic signed [VAL_W-1:0] target_ff, target_in;
   logic                    found_ff, found_in;
   logic [CW-1:0]           pos_ff, pos_in;

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;

   logic                    req_take;
   logic                    rsp_free;
   logic [CW-1:0]           mid_pk;
   logic [CW-1:0]           mid_bs;
   logic [CW-1:0]           mid_cur;
   opcode_type              req_op;
   logic signed [VAL_W-1:0] req_val;

   assign req_op  = opcode_type'(req_tuser);
   assign req_val = $signed(req_tdata);

   // Output slot is free when empty or being drained this cycle.
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_take   = req_tvalid && req_tready;

   // Peak search midpoint over [lo, hi]; value searches over [lo, hi).
   assign mid_pk  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_bs  = lo_ff + ((hi_ff - lo_ff - 1'b1) >> 1);
   assign mid_cur = (state_ff == S_PK_RD) ? mid_pk : mid_bs;

   assign rd_addr_a = mid_cur[IW-1:0];
   assign rd_addr_b = rd_addr_a + 1'b1;    // only used by peak probes, never wraps there

   assign mem_we    = req_take && (req_op == OP_PUSH) && (cnt_ff < CW'(MAX_ELEMENTS));
   assign mem_waddr = cnt_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_val;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      peak_in       = peak_ff;
      target_in     = target_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_op)
                  OP_PUSH: begin
                     rsp_tvalid_in = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_pos_in    = '0;
                     if (cnt_ff < CW'(MAX_ELEMENTS)) begin
                        cnt_in        = cnt_ff + 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_cnt_in    = CNT_W'(cnt_ff + 1'b1);
                     end else begin
                        rsp_status_in = ST_FULL;
                        rsp_cnt_in    = CNT_W'(cnt_ff);
                     end
                  end
                  OP_POP: begin
                     rsp_tvalid_in = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_pos_in    = '0;
                     if (cnt_ff != '0) begin
                        cnt_in        = cnt_ff - 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_cnt_in    = CNT_W'(cnt_ff - 1'b1);
                     end else begin
                        rsp_status_in = ST_EMPTY;
                        rsp_cnt_in    = CNT_W'(cnt_ff);
                     end
                  end
                  OP_QUERY: begin
                     target_in = req_val;
                     found_in  = 1'b0;
                     pos_in    = '0;
                     if (cnt_ff == '0) begin
                        // empty store: nothing to search
                        rsp_tvalid_in = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_found_in  = 1'b0;
                        rsp_pos_in    = '0;
                        rsp_cnt_in    = CNT_W'(cnt_ff);
                     end else begin
                        lo_in    = '0;
                        hi_in    = cnt_ff - 1'b1;
                        state_in = S_PK_RD;
                     end
                  end
                  default: begin
                     rsp_tvalid_in = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_found_in  = 1'b0;
                     rsp_pos_in    = '0;
                     rsp_cnt_in    = CNT_W'(cnt_ff);
                  end
               endcase
            end
         end

         S_PK_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_pk;
               state_in = S_PK_CMP;
            end else begin
               // peak found; rising part is [0, peak]
               peak_in  = lo_ff;
               lo_in    = '0;
               hi_in    = lo_ff + 1'b1;
               state_in = S_UP_RD;
            end
         end

         S_PK_CMP: begin
            // equal neighbors move right
            if (rd_a_ff > rd_b_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = S_PK_RD;
         end

         S_UP_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_bs;
               state_in = S_UP_CMP;
            end else begin
               // falling part is [peak+1, count)
               lo_in    = peak_ff + 1'b1;
               hi_in    = cnt_ff;
               state_in = S_DN_RD;
            end
         end

         S_UP_CMP: begin
            if (rd_a_ff == target_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = S_DONE;
            end else begin
               if (rd_a_ff > target_ff) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + 1'b1;
               end
               state_in = S_UP_RD;
            end
         end

         S_DN_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_bs;
               state_in = S_DN_CMP;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DN_CMP: begin
            if (rd_a_ff == target_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = S_DONE;
            end else begin
               if (rd_a_ff < target_ff) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + 1'b1;
               end
               state_in = S_DN_RD;
            end
         end

         S_DONE: begin
            // hold the result until the output slot frees up
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = found_ff ? ST_OK : ST_NOT_FOUND;
               rsp_found_in  = found_ff;
               rsp_pos_in    = POS_W'(pos_ff);
               rsp_cnt_in    = CNT_W'(cnt_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      peak_ff       <= peak_in;
      target_ff     <= target_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_pos_ff};
   assign rsp_tuser  = {rsp_found_ff, rsp_status_ff};

endmodule

[tb/sv/bas_result_checker.sv]
`timescale 1ns / 1ps

module bas_result_checker #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand_value (signed)
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [9:0] position, [20:10] element_count, [23:21] zero
   input  logic [2:0]  rsp_tuser,   // [1:0] status, [2] found
   output int          errors,
   output int          pending,
   output int          located_cnt,
   output int          missed_cnt,
   output int          full_cnt,
   output int          empty_cnt
);

   import bas_pkg::*;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [POS_W-1:0]   position;
      logic [CNT_W-1:0]   count;
   } outcome_type;

   logic signed [VAL_W-1:0] values [MAX_ELEMENTS];
   int                      fill;
   outcome_type             awaited_outcomes [$];

   // Peak by binary search (ties move right), then rising half ascending,
   // then falling half descending. -1 when the target is absent.
   function automatic int locate_target(logic signed [31:0] target);
      int lo, hi, mid, peak;
      if (fill == 0) return -1;
      lo = 0;
      hi = fill - 1;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (values[mid] > values[mid + 1]) hi = mid;
         else lo = mid + 1;
      end
      peak = lo;
      lo = 0;
      hi = peak;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (values[mid] == target) return mid;
         if (values[mid] > target) hi = mid - 1;
         else lo = mid + 1;
      end
      lo = peak + 1;
      hi = fill - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (values[mid] == target) return mid;
         if (values[mid] < target) hi = mid - 1;
         else lo = mid + 1;
      end
      return -1;
   endfunction

   function automatic outcome_type apply_request(opcode_type op, logic [31:0] operand);
      outcome_type o;
      int          idx;
      o = '0;
      o.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (fill >= MAX_ELEMENTS) begin
               o.status = ST_FULL;
               full_cnt++;
            end else begin
               values[fill] = operand;
               fill++;
            end
         end
         OP_POP: begin
            if (fill == 0) begin
               o.status = ST_EMPTY;
               empty_cnt++;
            end else begin
               fill--;
            end
         end
         OP_QUERY: begin
            idx = locate_target(operand);
            if (idx < 0) begin
               o.status = ST_NOT_FOUND;
               missed_cnt++;
            end else begin
               o.found = 1'b1;
               o.position = idx[POS_W-1:0];
               located_cnt++;
            end
         end
         default: ;
      endcase
      o.count = fill[CNT_W-1:0];
      return o;
   endfunction

   task automatic check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type taken;
      if (reset) begin
         fill = 0;
         awaited_outcomes.delete();
         errors = 0;
         located_cnt = 0;
         missed_cnt = 0;
         full_cnt = 0;
         empty_cnt = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken = apply_request(opcode_type'(req_tuser), req_tdata);
            awaited_outcomes.insert(awaited_outcomes.size(), taken);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected response, expected none, got tuser %0h tdata %0h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", int'(want.status), int'(rsp_tuser[1:0]));
               check_field("found", int'(want.found), int'(rsp_tuser[2]));
               check_field("position", int'(want.position), int'(rsp_tdata[9:0]));
               check_field("element_count", int'(want.count), int'(rsp_tdata[20:10]));
            end
         end
      end
      pending = awaited_outcomes.size();
   end

endmodule

[tb/sv/tb_bitonic_array_search.sv]
`timescale 1ns / 1ps

module tb_bitonic_array_search;

   import bas_pkg::*;

   localparam int MAX_ELEMENTS = 1024;
   // Slowest legal run is roughly 1750 requests; this cycle limit is well above its length.
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] operand_value (signed)
   logic [1:0]  req_tuser;    // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [9:0] position, [20:10] element_count, [23:21] zero
   logic [2:0]  rsp_tuser;    // [1:0] status, [2] found

   int errors, pending, located_cnt, missed_cnt, full_cnt, empty_cnt;

   bit          calm = 0;         // no idling on either side while set
   int          holds_asked = 0;  // long response hold-offs requested so far
   int          sent = 0;         // requests accepted, no-ops excluded
   int          cycles = 0;
   logic [31:0] held_vals [$];    // what the array should hold, for target picking

   bitonic_array_search #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   bas_result_checker #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending),
      .located_cnt(located_cnt),
      .missed_cnt (missed_cnt),
      .full_cnt   (full_cnt),
      .empty_cnt  (empty_cnt)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side. Random back-pressure about 22% of cycles unless calm;
   // each hold-off request from the stimulus keeps tready low while hold_left,
   // loaded from HOLD_CYCLES, counts down, so the block stalls with a request still offered.
   initial begin
      int hold_left;
      int holds_done;
      hold_left = 0;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done < holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 22) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One request: optional idle gap, then hold valid until accepted.
   // Entered and left at a falling edge; valid stays high between
   // back-to-back requests.
   task automatic send_req(opcode_type op, logic [31:0] operand);
      if (!calm && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= operand;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == OP_PUSH && held_vals.size() < MAX_ELEMENTS)
         held_vals.insert(held_vals.size(), operand);
      if (op == OP_POP && held_vals.size() > 0)
         void'(held_vals.pop_back());
      if (op != OP_NOP)
         sent++;
   endtask

   // Mostly stored values (so the searches hit both halves), some near misses,
   // some fully random and the signed extremes.
   function automatic logic [31:0] pick_target();
      int          r;
      int          idx;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (held_vals.size() == 0 || r < 25) begin
         v = $urandom();
      end else if (r < 35) begin
         v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         idx = $urandom_range(0, held_vals.size() - 1);
         v = held_vals[idx];
         if (r < 50) v = v + ($urandom_range(0, 1) ? 1 : -1);
      end
      return v;
   endfunction

   // Push a bitonic run: rising by random steps, then falling, saturating
   // at the signed limits (which makes plateaus). Step scale varies from
   // tiny (lots of equal neighbours) to huge. A noisy run slips in stray
   // values that break the shape.
   task automatic push_bitonic(int len, bit noisy);
      logic [31:0] v;
      longint      nv;
      longint      amt;
      int          scale;
      int          rise;
      case ($urandom_range(0, 3))
         0:       scale = 3;
         1:       scale = 1000;
         2:       scale = 1 << 20;
         default: scale = 1 << 28;
      endcase
      v = $urandom();
      rise = $urandom_range(0, len);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 99) < 5)
            send_req(OP_PUSH, $urandom());
         send_req(OP_PUSH, v);
         amt = longint'($urandom_range(0, scale));
         nv = longint'($signed(v)) + ((i < rise) ? amt : -amt);
         if (nv > 64'sd2147483647)  nv = 64'sd2147483647;
         if (nv < -64'sd2147483648) nv = -64'sd2147483648;
         v = nv[31:0];
      end
   endtask

   // Queries with a sprinkling of stray pushes, pops and no-ops.
   task automatic run_queries(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 2))
               0:       send_req(OP_PUSH, $urandom());
               1:       send_req(OP_POP, $urandom());
               default: send_req(OP_NOP, $urandom());
            endcase
         end else begin
            send_req(OP_QUERY, pick_target());
         end
      end
   endtask

   task automatic drain_array();
      while (held_vals.size() > 0) send_req(OP_POP, $urandom());
   endtask

   initial begin
      int ep;
      int len;
      int r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_NOP;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-array cases, the no-op opcode, signed extremes,
      // a target in each half, equal neighbours at the peak.
      send_req(OP_POP,   32'h0000_0000);   // pop on empty
      send_req(OP_QUERY, 32'h0000_0000);   // query on empty
      send_req(OP_NOP,   32'hFFFF_FFFF);   // ignored opcode
      send_req(OP_PUSH,  32'h8000_0000);
      send_req(OP_QUERY, 32'h8000_0000);
      send_req(OP_QUERY, 32'h7FFF_FFFF);
      send_req(OP_PUSH,  32'h7FFF_FFFF);
      send_req(OP_PUSH,  32'h0000_0000);
      send_req(OP_PUSH,  32'h8000_0000);
      send_req(OP_QUERY, 32'h7FFF_FFFF);   // at the peak
      send_req(OP_QUERY, 32'h0000_0000);   // falling half
      send_req(OP_QUERY, 32'h8000_0000);   // rising half wins
      send_req(OP_QUERY, 32'hFFFF_FFFF);   // absent
      drain_array();
      send_req(OP_PUSH,  32'h0000_0007);
      send_req(OP_PUSH,  32'h0000_0007);   // equal neighbours
      send_req(OP_QUERY, 32'h0000_0007);
      send_req(OP_PUSH,  32'hFFFF_FFFF);
      send_req(OP_QUERY, 32'hFFFF_FFFF);
      send_req(OP_QUERY, 32'h5555_5555);
      send_req(OP_NOP,   32'h0000_0000);
      drain_array();

      // Random episodes: build a bitonic array, search it, tear it down.
      ep = 0;
      while (sent < 700) begin
         calm = (ep >= 4 && ep < 7);
         if (ep == 2) holds_asked++;
         r = $urandom_range(0, 9);
         if (r < 2)      len = $urandom_range(0, 3);
         else if (r < 9) len = $urandom_range(4, 40);
         else            len = $urandom_range(41, 100);
         push_bitonic(len, (ep % 3) == 1);
         run_queries($urandom_range(6, 14));
         drain_array();
         if ($urandom_range(0, 1)) send_req(OP_POP, $urandom());
         if ($urandom_range(0, 99) < 30) send_req(OP_QUERY, $urandom());
         ep++;
      end

      // Fill to capacity with no idling, then overflow and full-depth searches.
      calm = 1;
      push_bitonic(MAX_ELEMENTS, 1'b0);
      calm = 0;
      send_req(OP_PUSH, $urandom());
      send_req(OP_PUSH, $urandom());
      holds_asked++;
      run_queries(10);
      repeat (3) send_req(OP_POP, $urandom());
      run_queries(3);
      while (held_vals.size() < MAX_ELEMENTS) send_req(OP_PUSH, 32'h8000_0000);
      send_req(OP_PUSH, $urandom());
      send_req(OP_QUERY, 32'h8000_0000);
      req_tvalid <= 1'b0;

      // Let every response come back, then allow for a full query's latency.
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("Ran %0d requests: %0d targets located, %0d absent, %0d full pushes, %0d empty pops.",
               sent, located_cnt, missed_cnt, full_cnt, empty_cnt);
      $display("Array sizes spanned empty to %0d entries under random and long response stalls.",
               MAX_ELEMENTS);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
